// File: hdl/nbg_pkg.sv
package nbg_pkg;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

    // request opcodes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // register indexes; each register sits at byte address 8*index
    localparam logic [2:0] REG_GRAV  = 3'd0;
    localparam logic [2:0] REG_DT    = 3'd1;
    localparam logic [2:0] REG_DAMP  = 3'd2;
    localparam logic [2:0] REG_SOFT  = 3'd3;
    localparam logic [2:0] REG_COUNT = 3'd4;

    // saturating signed add
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63])
        begin
            return sum[64] ? SMIN : SMAX;
        end
        return sum[63:0];
    endfunction

    // saturating signed subtract
    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] dif;
        dif = {a[63], a} - {b[63], b};
        if (dif[64] != dif[63])
        begin
            return dif[64] ? SMIN : SMAX;
        end
        return dif[63:0];
    endfunction

endpackage

// File: hdl/nbg_mul.sv
// Q32.32 signed multiply, saturating, from four 32x32 partial products.
module nbg_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] p
);

    logic               active_reg;
    logic [2:0]         cnt_reg;
    logic [63:0]        ua_reg;
    logic [63:0]        ub_reg;
    logic               neg_reg;
    logic [63:0]        pp_reg;
    logic [127:0]       acc_reg;
    logic               done_reg;
    logic signed [63:0] p_reg;

    logic [31:0]  xh;
    logic [31:0]  yh;
    logic [6:0]   sh;
    logic [127:0] acc_next;
    logic [63:0]  limit;
    logic [63:0]  qmag;

    always_comb
    begin
        unique case (cnt_reg)
            3'd0:    begin xh = ua_reg[31:0];  yh = ub_reg[31:0];  end
            3'd1:    begin xh = ua_reg[31:0];  yh = ub_reg[63:32]; end
            3'd2:    begin xh = ua_reg[63:32]; yh = ub_reg[31:0];  end
            default: begin xh = ua_reg[63:32]; yh = ub_reg[63:32]; end
        endcase
        // shift of the product made in the previous step
        unique case (cnt_reg)
            3'd2, 3'd3: sh = 7'd32;
            3'd4:       sh = 7'd64;
            default:    sh = 7'd0;
        endcase
        acc_next = acc_reg + ({64'd0, pp_reg} << sh);
        limit = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (acc_reg[127:96] != 32'd0)
        begin
            qmag = limit;
        end
        else if (acc_reg[95:32] > limit)
        begin
            qmag = limit;
        end
        else
        begin
            qmag = acc_reg[95:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 3'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= 3'd0;
                acc_reg    <= 128'd0;
                neg_reg    <= a[63] ^ b[63];
                ua_reg     <= a[63] ? 64'(-a) : 64'(a);
                ub_reg     <= b[63] ? 64'(-b) : 64'(b);
            end
            else if (active_reg)
            begin
                if (cnt_reg <= 3'd3)
                begin
                    pp_reg <= 64'(xh) * 64'(yh);
                end
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                begin
                    acc_reg <= acc_next;
                end
                if (cnt_reg == 3'd5)
                begin
                    p_reg      <= neg_reg ? 64'(-qmag) : qmag;
                    done_reg   <= 1'b1;
                    active_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// File: hdl/nbg_div.sv
// (num << 32) / den, one quotient bit a cycle, saturating to the signed max.
module nbg_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] q
);

    logic        active_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] dvd_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [95:0] quo_reg;
    logic        done_reg;
    logic [63:0] q_reg;

    logic [63:0] rs;

    assign rs = {rem_reg[62:0], dvd_reg[95]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 7'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == 64'd0)
                begin
                    q_reg    <= 64'(nbg_pkg::SMAX);
                    done_reg <= 1'b1;
                end
                else
                begin
                    active_reg <= 1'b1;
                    cnt_reg    <= 7'd96;
                    dvd_reg    <= {num, 32'd0};
                    den_reg    <= den;
                    rem_reg    <= 64'd0;
                    quo_reg    <= 96'd0;
                end
            end
            else if (active_reg)
            begin
                if (cnt_reg == 7'd0)
                begin
                    q_reg      <= (quo_reg[95:63] != 33'd0) ? 64'(nbg_pkg::SMAX)
                                                            : quo_reg[63:0];
                    done_reg   <= 1'b1;
                    active_reg <= 1'b0;
                end
                else
                begin
                    dvd_reg <= {dvd_reg[94:0], 1'b0};
                    if (rs >= den_reg)
                    begin
                        rem_reg <= rs - den_reg;
                        quo_reg <= {quo_reg[94:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rs;
                        quo_reg <= {quo_reg[94:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// File: hdl/nbody_gravity_step.sv
// A load request holds busy while the three axes of the body are written; a step request
//   holds it through every pair of bodies in use and then the position update, almost all
//   of it in the bit-serial divider (one quotient bit a cycle).
// Throughput: one request at a time; busy stays high until the last position.
// Results leave as one-cycle strobes; the receiver cannot stall them.
// Reset: rst_n is asynchronous, active low; control and configuration registers return to their defaults.
module nbody_gravity_step #(
    parameter int MAX_BODIES      = 32,
    parameter int ROOT_ITERATIONS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [5:0]         body_index,
    input  logic signed [63:0] pos_x_in,
    input  logic signed [63:0] pos_y_in,
    input  logic signed [63:0] pos_z_in,
    input  logic signed [63:0] vel_x_in,
    input  logic signed [63:0] vel_y_in,
    input  logic signed [63:0] vel_z_in,
    // result channel
    output logic               result_valid,
    output logic [5:0]         out_index,
    output logic signed [63:0] pos_x_out,
    output logic signed [63:0] pos_y_out,
    output logic signed [63:0] pos_z_out,
    output logic               last_body,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(3 * MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int KW = $clog2(ROOT_ITERATIONS);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_PAIR, S_RD, S_DIFF, S_TOP, S_ROOT, S_R2, S_R3,
        S_NUM, S_H, S_VEL, S_WB, S_NEXT, S_MRD, S_MCAP, S_MMUL
    } state_t;

    typedef logic signed [63:0] word_t;

    // configuration registers
    logic [62:0] grav_reg;
    logic [62:0] dt_reg;
    logic [33:0] damp_reg;
    logic [62:0] soft_reg;
    logic [6:0]  count_reg;

    // body stores
    word_t pos_mem [3*MAX_BODIES];
    word_t vel_mem [3*MAX_BODIES];
    word_t pos_rd;
    word_t vel_rd;
    logic          pos_we;
    logic          vel_we;
    logic [AW-1:0] raddr;
    logic [AW-1:0] pos_waddr;
    logic [AW-1:0] vel_waddr;
    word_t         pos_wdata;
    word_t         vel_wdata;

    // sequencer
    state_t          state_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   j_reg;
    logic [1:0]      ax_reg;
    logic [2:0]      rc_reg;
    logic            side_reg;
    logic            ph_reg;
    logic            wait_reg;
    logic [5:0]      m_reg;
    logic [KW-1:0]   k_reg;
    word_t pa_reg [3];
    word_t pb_reg [3];
    word_t va_reg [3];
    word_t vb_reg [3];
    word_t d_reg  [3];
    word_t in_pos_reg [3];
    word_t in_vel_reg [3];
    word_t s_reg;
    word_t r_reg;
    word_t r2_reg;
    word_t num_reg;
    word_t h_reg;
    word_t tmp_reg;
    word_t out_pos_reg [3];
    logic        result_valid_reg;
    logic [5:0]  out_index_reg;
    logic        last_body_reg;

    // shared units
    logic  mul_start_reg;
    word_t mul_a_reg;
    word_t mul_b_reg;
    logic  mul_done;
    word_t mul_p;
    logic        div_start_reg;
    logic [63:0] div_num_reg;
    logic [63:0] div_den_reg;
    logic        div_done;
    logic [63:0] div_q;

    logic          accept;
    logic          cfg_wr;
    logic [CW-1:0] n_calc;
    word_t         vel_op;
    word_t         diff_op;
    word_t         mv_pos;
    logic [64:0]   root_sum;
    logic [63:0]   root_sat;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] j_inc;

    function automatic logic [AW-1:0] entry(input logic [CW-1:0] b, input logic [1:0] a);
        return AW'(3 * int'(b) + int'(a));
    endfunction

    nbg_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    nbg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .q     (div_q)
    );

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // bodies in use are capped at the store size
    assign n_calc = (int'(count_reg) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(count_reg);
    assign i_inc  = i_reg + CW'(1);
    assign j_inc  = j_reg + CW'(1);

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg  <= 63'd4294967296;
            dt_reg    <= 63'd42949673;
            damp_reg  <= 34'd4294967296;
            soft_reg  <= 63'd4294967;
            count_reg <= 7'd32;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                nbg_pkg::REG_GRAV:  grav_reg  <= pwdata[62:0];
                nbg_pkg::REG_DT:    dt_reg    <= pwdata[62:0];
                nbg_pkg::REG_DAMP:  damp_reg  <= pwdata[33:0];
                nbg_pkg::REG_SOFT:  soft_reg  <= pwdata[62:0];
                nbg_pkg::REG_COUNT: count_reg <= pwdata[6:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            nbg_pkg::REG_GRAV:  prdata = {1'b0, grav_reg};
            nbg_pkg::REG_DT:    prdata = {1'b0, dt_reg};
            nbg_pkg::REG_DAMP:  prdata = {30'd0, damp_reg};
            nbg_pkg::REG_SOFT:  prdata = {1'b0, soft_reg};
            nbg_pkg::REG_COUNT: prdata = {57'd0, count_reg};
            default:   prdata = 64'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Body stores: one write and one registered read each per cycle
    // ---------------------------------------------------------------
    always_comb
    begin
        // read address: pair fetch walks body i then body j
        if (state_reg == S_RD)
        begin
            raddr = (rc_reg < 3'd3) ? entry(i_reg, rc_reg[1:0])
                                    : entry(j_reg, 2'(rc_reg - 3'd3));
        end
        else
        begin
            raddr = entry(i_reg, ax_reg);
        end

        mv_pos = nbg_pkg::sadd(tmp_reg, mul_p);

        pos_we    = (state_reg == S_LOAD) || (state_reg == S_MMUL && mul_done);
        pos_waddr = entry(i_reg, ax_reg);
        pos_wdata = (state_reg == S_LOAD) ? in_pos_reg[ax_reg] : mv_pos;

        vel_we    = (state_reg == S_LOAD) || (state_reg == S_WB);
        if (state_reg == S_WB)
        begin
            vel_waddr = (rc_reg < 3'd3) ? entry(i_reg, rc_reg[1:0])
                                        : entry(j_reg, 2'(rc_reg - 3'd3));
            vel_wdata = (rc_reg < 3'd3) ? va_reg[rc_reg[1:0]] : vb_reg[2'(rc_reg - 3'd3)];
        end
        else
        begin
            vel_waddr = entry(i_reg, ax_reg);
            vel_wdata = in_vel_reg[ax_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (vel_we)
        begin
            vel_mem[vel_waddr] <= vel_wdata;
        end
        pos_rd <= pos_mem[raddr];
        vel_rd <= vel_mem[raddr];
    end

    // operands of the velocity update: body i pulls toward j, body j toward i
    always_comb
    begin
        diff_op  = side_reg ? nbg_pkg::ssub(pa_reg[ax_reg], pb_reg[ax_reg]) : d_reg[ax_reg];
        vel_op   = side_reg ? vb_reg[ax_reg] : va_reg[ax_reg];
        // Newton step: both terms are non-negative, clamp the sum
        root_sum = {1'b0, r_reg} + {1'b0, div_q};
        root_sat = (root_sum > 65'(nbg_pkg::SMAX)) ? 64'(nbg_pkg::SMAX) : root_sum[63:0];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wait_reg         <= 1'b0;
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            ax_reg           <= 2'd0;
            rc_reg           <= 3'd0;
            i_reg            <= '0;
            j_reg            <= '0;
            n_reg            <= '0;
            side_reg         <= 1'b0;
            ph_reg           <= 1'b0;
        end
        else
        begin
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == nbg_pkg::CMD_STEP)
                        begin
                            state_reg <= S_PAIR;
                        end
                        else if (int'(body_index) < MAX_BODIES)
                        begin
                            // latch the body and write it one axis at a time
                            i_reg         <= CW'(body_index);
                            ax_reg        <= 2'd0;
                            in_pos_reg[0] <= pos_x_in;
                            in_pos_reg[1] <= pos_y_in;
                            in_pos_reg[2] <= pos_z_in;
                            in_vel_reg[0] <= vel_x_in;
                            in_vel_reg[1] <= vel_y_in;
                            in_vel_reg[2] <= vel_z_in;
                            state_reg     <= S_LOAD;
                        end
                    end
                end

                S_LOAD:
                begin
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end

                S_PAIR:
                begin
                    n_reg  <= n_calc;
                    ax_reg <= 2'd0;
                    rc_reg <= 3'd0;
                    if (n_calc == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (n_calc == CW'(1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_MRD;
                    end
                    else
                    begin
                        i_reg     <= CW'(1);
                        j_reg     <= '0;
                        state_reg <= S_RD;
                    end
                end

                S_RD:
                begin
                    // data of the previous read address arrives now
                    if (rc_reg >= 3'd1 && rc_reg <= 3'd3)
                    begin
                        pa_reg[2'(rc_reg - 3'd1)] <= pos_rd;
                        va_reg[2'(rc_reg - 3'd1)] <= vel_rd;
                    end
                    else if (rc_reg >= 3'd4)
                    begin
                        pb_reg[2'(rc_reg - 3'd4)] <= pos_rd;
                        vb_reg[2'(rc_reg - 3'd4)] <= vel_rd;
                    end
                    if (rc_reg == 3'd6)
                    begin
                        s_reg     <= word_t'({1'b0, soft_reg});
                        ax_reg    <= 2'd0;
                        state_reg <= S_DIFF;
                    end
                    else
                    begin
                        rc_reg <= rc_reg + 3'd1;
                    end
                end

                S_DIFF:
                begin
                    if (!wait_reg)
                    begin
                        d_reg[ax_reg] <= nbg_pkg::ssub(pb_reg[ax_reg], pa_reg[ax_reg]);
                        mul_a_reg     <= nbg_pkg::ssub(pb_reg[ax_reg], pa_reg[ax_reg]);
                        mul_b_reg     <= nbg_pkg::ssub(pb_reg[ax_reg], pa_reg[ax_reg]);
                        mul_start_reg <= 1'b1;
                        wait_reg      <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        s_reg    <= nbg_pkg::sadd(s_reg, mul_p);
                        wait_reg <= 1'b0;
                        if (ax_reg == 2'd2)
                        begin
                            m_reg     <= 6'd63;
                            state_reg <= S_TOP;
                        end
                        else
                        begin
                            ax_reg <= ax_reg + 2'd1;
                        end
                    end
                end

                S_TOP:
                begin
                    // walk down to the top set bit for the root's first guess
                    if (s_reg == '0)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_R2;
                    end
                    else if (s_reg[m_reg])
                    begin
                        r_reg     <= word_t'(64'd1 << ((7'(m_reg) + 7'd32) / 7'd2 + 7'd1));
                        k_reg     <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        m_reg <= m_reg - 6'd1;
                    end
                end

                S_ROOT:
                begin
                    if (!wait_reg)
                    begin
                        div_num_reg   <= 64'(s_reg);
                        div_den_reg   <= 64'(r_reg);
                        div_start_reg <= 1'b1;
                        wait_reg      <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        r_reg    <= word_t'(root_sat >> 1);
                        wait_reg <= 1'b0;
                        if (int'(k_reg) == ROOT_ITERATIONS - 1)
                        begin
                            state_reg <= S_R2;
                        end
                        else
                        begin
                            k_reg <= k_reg + KW'(1);
                        end
                    end
                end

                S_R2, S_R3, S_NUM:
                begin
                    if (!wait_reg)
                    begin
                        if (state_reg == S_NUM)
                        begin
                            mul_a_reg <= word_t'({1'b0, dt_reg});
                            mul_b_reg <= word_t'({1'b0, grav_reg});
                        end
                        else
                        begin
                            mul_a_reg <= (state_reg == S_R2) ? r_reg : r2_reg;
                            mul_b_reg <= r_reg;
                        end
                        mul_start_reg <= 1'b1;
                        wait_reg      <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        if (state_reg == S_NUM)
                        begin
                            num_reg   <= mul_p;
                            state_reg <= S_H;
                        end
                        else
                        begin
                            // r squared, then r cubed, in the same register
                            r2_reg    <= mul_p;
                            state_reg <= (state_reg == S_R2) ? S_R3 : S_NUM;
                        end
                    end
                end

                S_H:
                begin
                    if (!wait_reg)
                    begin
                        div_num_reg   <= 64'(num_reg);
                        div_den_reg   <= 64'(r2_reg);
                        div_start_reg <= 1'b1;
                        wait_reg      <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        h_reg     <= word_t'(div_q);
                        wait_reg  <= 1'b0;
                        ax_reg    <= 2'd0;
                        side_reg  <= 1'b0;
                        ph_reg    <= 1'b0;
                        state_reg <= S_VEL;
                    end
                end

                S_VEL:
                begin
                    if (!wait_reg)
                    begin
                        mul_a_reg     <= ph_reg ? tmp_reg : h_reg;
                        mul_b_reg     <= ph_reg ? word_t'({30'd0, damp_reg}) : diff_op;
                        mul_start_reg <= 1'b1;
                        wait_reg      <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        wait_reg <= 1'b0;
                        if (!ph_reg)
                        begin
                            tmp_reg <= nbg_pkg::sadd(vel_op, mul_p);
                            ph_reg  <= 1'b1;
                        end
                        else
                        begin
                            ph_reg <= 1'b0;
                            if (side_reg)
                            begin
                                vb_reg[ax_reg] <= mul_p;
                            end
                            else
                            begin
                                va_reg[ax_reg] <= mul_p;
                            end
                            if (ax_reg == 2'd2)
                            begin
                                ax_reg <= 2'd0;
                                if (side_reg)
                                begin
                                    rc_reg    <= 3'd0;
                                    state_reg <= S_WB;
                                end
                                else
                                begin
                                    side_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                ax_reg <= ax_reg + 2'd1;
                            end
                        end
                    end
                end

                S_WB:
                begin
                    if (rc_reg == 3'd5)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        rc_reg <= rc_reg + 3'd1;
                    end
                end

                S_NEXT:
                begin
                    // advance to the next pair, j ascending inside i
                    rc_reg <= 3'd0;
                    ax_reg <= 2'd0;
                    if (j_inc == i_reg)
                    begin
                        if (i_inc == n_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_MRD;
                        end
                        else
                        begin
                            i_reg     <= i_inc;
                            j_reg     <= '0;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_inc;
                        state_reg <= S_RD;
                    end
                end

                S_MRD:
                begin
                    state_reg <= S_MCAP;
                end

                S_MCAP:
                begin
                    tmp_reg       <= pos_rd;
                    mul_a_reg     <= word_t'({1'b0, dt_reg});
                    mul_b_reg     <= vel_rd;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MMUL;
                end

                S_MMUL:
                begin
                    if (mul_done)
                    begin
                        out_pos_reg[ax_reg] <= mv_pos;
                        if (ax_reg == 2'd2)
                        begin
                            // emit the body once all three axes have moved
                            result_valid_reg <= 1'b1;
                            out_index_reg    <= 6'(i_reg);
                            last_body_reg    <= (i_inc == n_reg);
                            ax_reg           <= 2'd0;
                            if (i_inc == n_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg     <= i_inc;
                                state_reg <= S_MRD;
                            end
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_MRD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign out_index    = out_index_reg;
    assign pos_x_out    = out_pos_reg[0];
    assign pos_y_out    = out_pos_reg[1];
    assign pos_z_out    = out_pos_reg[2];
    assign last_body    = last_body_reg;

endmodule

// File: hdl/nbg_checker.sv
module nbg_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic result_valid,
    input logic last_body
);

    // an accepted step request always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == nbg_pkg::CMD_STEP) |=> busy)
        else $error("step request accepted but block not busy");

    // results come only out of a running step
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a running step");

    // more bodies follow only while still busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_body |-> busy)
        else $error("block idle before the last body");

    // strobes never run back to back
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held two cycles");

endmodule

bind nbody_gravity_step nbg_checker u_nbg_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .last_body    (last_body)
);
